>>> rtl/cartesian_to_spherical_core_macros.svh
// assertion macros for the cartesian to spherical core
// expects clk and rst_n in the scope that uses them
`ifndef CARTESIAN_TO_SPHERICAL_CORE_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define C2S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define C2S_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define C2S_ASSERT(lbl, prop, msg)
`define C2S_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/c2s_pkg.sv
// shared constants for the cartesian to spherical core
// angle format, gain constants and the cordic arctangent table; no dependencies
`default_nettype none

package c2s_pkg;

  // fraction bits kept below the input lsb
  localparam int GUARD = 16;

  // angle accumulator: 32 bits, 2^31 is pi
  localparam int ANGLE_W = 32;
  localparam logic [ANGLE_W-1:0] ANGLE_PI        = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF_PI   = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_3HALF_PI  = 32'hC000_0000;

  // inverse cordic gain, q30
  localparam int GAIN_W    = 30;
  localparam int GAIN_LO_W = 25;
  localparam int GAIN_BASE = 652032874;
  localparam int GAIN_TAIL = 434688583;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [ANGLE_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

>>> rtl/c2s_vector_pipe.sv
// pipelined cordic vectoring pass with gain compensation of the length
// uses c2s_pkg for the angle format, gain constants and arctangent table
`default_nettype none

module c2s_vector_pipe #(
  parameter int W      = 35,
  parameter int STEPS  = 16,
  parameter int SIDE_W = 17
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic signed [W-1:0]               in_a,
  input  logic signed [W-1:0]               in_b,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_v,
  output logic [c2s_pkg::ANGLE_W-1:0]       out_angle,
  output logic [W-1:0]                      out_len,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int AW      = c2s_pkg::ANGLE_W;
  localparam int GW      = c2s_pkg::GAIN_W;
  localparam int LO_W    = c2s_pkg::GAIN_LO_W;
  localparam int HI_W    = W - 1 - LO_W;
  localparam int SUM_W   = W + GW;
  localparam int GAIN_SH = 2 * STEPS;
  localparam logic [GW-1:0] GAIN = GW'(c2s_pkg::GAIN_BASE +
    ((GAIN_SH < GW) ? (c2s_pkg::GAIN_TAIL >> GAIN_SH) : 0));
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (GW - 1);

  // stage 0 is the pre-rotation, stage i+1 holds the result of step i
  logic                v_r      [STEPS+1];
  logic                v_nxt    [STEPS+1];
  logic signed [W-1:0] x_r      [STEPS+1];
  logic signed [W-1:0] x_nxt    [STEPS+1];
  logic signed [W-1:0] y_r      [STEPS+1];
  logic signed [W-1:0] y_nxt    [STEPS+1];
  logic [AW-1:0]       acc_r    [STEPS+1];
  logic [AW-1:0]       acc_nxt  [STEPS+1];
  logic [SIDE_W-1:0]   side_r   [STEPS+1];
  logic [SIDE_W-1:0]   side_nxt [STEPS+1];

  // gain multiply, split into two partial products
  logic [W-2:0]        mag;
  logic [LO_W+GW-1:0]  lo_prod_nxt, lo_prod_r;
  logic [HI_W+GW-1:0]  hi_prod_nxt, hi_prod_r;
  logic                va_r;
  logic [AW-1:0]       acc_a_r;
  logic [SIDE_W-1:0]   side_a_r;

  logic [SUM_W-1:0]    sum;
  logic [W-1:0]        len_nxt, len_r;
  logic                vb_r;
  logic [AW-1:0]       acc_b_r;
  logic [SIDE_W-1:0]   side_b_r;

  always_comb begin
    // start in the right half plane
    v_nxt[0]    = in_v;
    side_nxt[0] = in_side;
    x_nxt[0]    = in_a[W-1] ? -in_a : in_a;
    y_nxt[0]    = in_a[W-1] ? -in_b : in_b;
    acc_nxt[0]  = in_a[W-1] ? c2s_pkg::ANGLE_PI : '0;
    for (int i = 0; i < STEPS; i++) begin
      v_nxt[i+1]    = v_r[i];
      side_nxt[i+1] = side_r[i];
      if (!y_r[i][W-1]) begin
        x_nxt[i+1]   = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1]   = y_r[i] - (x_r[i] >>> i);
        acc_nxt[i+1] = acc_r[i] + c2s_pkg::ATAN_TAB[i];
      end else begin
        x_nxt[i+1]   = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1]   = y_r[i] + (x_r[i] >>> i);
        acc_nxt[i+1] = acc_r[i] - c2s_pkg::ATAN_TAB[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= STEPS; i++) v_r[i] <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      for (int i = 0; i <= STEPS; i++) v_r[i] <= v_nxt[i];
      va_r <= v_r[STEPS];
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= STEPS; i++) begin
        x_r[i]    <= x_nxt[i];
        y_r[i]    <= y_nxt[i];
        acc_r[i]  <= acc_nxt[i];
        side_r[i] <= side_nxt[i];
      end
      lo_prod_r <= lo_prod_nxt;
      hi_prod_r <= hi_prod_nxt;
      acc_a_r   <= acc_r[STEPS];
      side_a_r  <= side_r[STEPS];
      len_r     <= len_nxt;
      acc_b_r   <= acc_a_r;
      side_b_r  <= side_a_r;
    end
  end

  // negative length is clamped to zero before scaling
  assign mag = x_r[STEPS][W-1] ? '0 : x_r[STEPS][W-2:0];
  assign lo_prod_nxt = {{GW{1'b0}}, mag[LO_W-1:0]} * {{LO_W{1'b0}}, GAIN};
  assign hi_prod_nxt = {{GW{1'b0}}, mag[W-2:LO_W]} * {{HI_W{1'b0}}, GAIN};

  assign sum = (SUM_W'(hi_prod_r) << LO_W) + SUM_W'(lo_prod_r) + RND;
  assign len_nxt = sum[SUM_W-1:GW];

  assign out_v     = vb_r;
  assign out_angle = acc_b_r;
  assign out_len   = len_r;
  assign out_side  = side_b_r;

endmodule

`default_nettype wire

>>> rtl/cartesian_to_spherical_core.sv
// top level of the cartesian to spherical core: two vectoring passes and output buffer
// depends on c2s_pkg, c2s_vector_pipe and cartesian_to_spherical_core_macros.svh
`default_nettype none

`include "cartesian_to_spherical_core_macros.svh"

// Converts a signed fixed-point point (x, y, z) into azimuth atan2(y, x), polar
// angle from +z (0 to pi) and length. Angles are binary: 2^(DATA_WIDTH-1) is pi.
// Azimuth of exactly pi reads as the most negative code, a polar angle of pi
// saturates to the field maximum, and a point on the z axis gives azimuth 0.
// The core takes one point per clock while in_ready is high. Each point passes
// a cordic vectoring pipeline on (x, y), then a second one on (z, planar length);
// each pass is one pre-rotation stage, CORDIC_STEPS micro-rotation stages and
// two gain-multiply stages. A two-entry output buffer lets the pipeline run one
// more point while out_ready is low; in_ready drops only once that spare entry
// is in use.

module cartesian_to_spherical_core #(
  parameter int DATA_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_x_in,
  input  logic signed [DATA_WIDTH-1:0] in_y_in,
  input  logic signed [DATA_WIDTH-1:0] in_z_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_azimuth,
  output logic [DATA_WIDTH-2:0]        out_polar_angle,
  output logic [DATA_WIDTH-1:0]        out_radius
);

  localparam int DW    = DATA_WIDTH;
  localparam int GUARD = c2s_pkg::GUARD;
  localparam int W     = DW + GUARD + 3;
  localparam int EXT   = W - DW - GUARD;
  localparam int RW    = W - GUARD;
  localparam int AW    = c2s_pkg::ANGLE_W;
  localparam int S1_W  = DW + 1;
  localparam int S2_W  = 2 * DW + 1;
  localparam logic [AW-1:0] RND_HALF = (DW < AW) ? (AW'(1) << (AW - 1 - DW)) : '0;
  localparam logic [W-1:0]  LEN_HALF = W'(1) << (GUARD - 1);

  logic en;

  // first pass on (x, y)
  logic                zero1;
  logic signed [W-1:0] a1, b1;
  logic [S1_W-1:0]     side1_in;
  logic                p1_v;
  logic [AW-1:0]       p1_ang;
  logic [W-1:0]        p1_len;
  logic [S1_W-1:0]     p1_side;

  // second pass on (z, planar length)
  logic [DW-1:0]       p1_z;
  logic [AW-1:0]       az_sum;
  logic signed [W-1:0] a2, b2;
  logic [S2_W-1:0]     side2_in;
  logic                p2_v;
  logic [AW-1:0]       p2_ang;
  logic [W-1:0]        p2_len;
  logic [S2_W-1:0]     p2_side;

  // result formatting
  logic [DW-1:0]       p2_az, p2_z, z_abs;
  logic                p2_zero;
  logic [AW-1:0]       u, t, ph_sum;
  logic [DW-1:0]       ph_full;
  logic [W-1:0]        r_sum;
  logic [RW-1:0]       r_full;
  logic [DW-1:0]       res_az, res_rad;
  logic [DW-2:0]       res_ph;

  // output register and skid entry
  logic                out_v_r, skid_v_r;
  logic [DW-1:0]       out_az_r, out_rad_r, skid_az_r, skid_rad_r;
  logic [DW-2:0]       out_ph_r, skid_ph_r;
  logic                out_free;

  assign en       = !skid_v_r;
  assign in_ready = en;

  assign zero1    = (in_x_in == '0) && (in_y_in == '0);
  assign a1       = {{EXT{in_x_in[DW-1]}}, in_x_in, {GUARD{1'b0}}};
  assign b1       = {{EXT{in_y_in[DW-1]}}, in_y_in, {GUARD{1'b0}}};
  assign side1_in = {zero1, in_z_in};

  c2s_vector_pipe #(
    .W      (W),
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (S1_W)
  ) u_pass1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (in_valid),
    .in_a      (a1),
    .in_b      (b1),
    .in_side   (side1_in),
    .out_v     (p1_v),
    .out_angle (p1_ang),
    .out_len   (p1_len),
    .out_side  (p1_side)
  );

  assign p1_z     = p1_side[DW-1:0];
  assign az_sum   = p1_ang + RND_HALF;
  assign a2       = {{EXT{p1_z[DW-1]}}, p1_z, {GUARD{1'b0}}};
  assign b2       = p1_len;
  assign side2_in = {p1_side[DW], p1_z, az_sum[AW-1 -: DW]};

  c2s_vector_pipe #(
    .W      (W),
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (S2_W)
  ) u_pass2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (p1_v),
    .in_a      (a2),
    .in_b      (b2),
    .in_side   (side2_in),
    .out_v     (p2_v),
    .out_angle (p2_ang),
    .out_len   (p2_len),
    .out_side  (p2_side)
  );

  assign p2_az   = p2_side[DW-1:0];
  assign p2_z    = p2_side[2*DW-1:DW];
  assign p2_zero = p2_side[2*DW];
  assign z_abs   = p2_z[DW-1] ? (~p2_z + DW'(1)) : p2_z;

  always_comb begin
    // read the angle in [-pi/2, 3pi/2) and clamp to [0, pi]
    u = p2_ang + c2s_pkg::ANGLE_HALF_PI;
    if (u < c2s_pkg::ANGLE_HALF_PI) begin
      t = '0;
    end else if (u > c2s_pkg::ANGLE_3HALF_PI) begin
      t = c2s_pkg::ANGLE_PI;
    end else begin
      t = u - c2s_pkg::ANGLE_HALF_PI;
    end
    ph_sum  = t + RND_HALF;
    ph_full = ph_sum[AW-1 -: DW];

    r_sum  = p2_len + LEN_HALF;
    r_full = r_sum[W-1:GUARD];

    if (p2_zero) begin
      res_az  = '0;
      res_ph  = p2_z[DW-1] ? '1 : '0;
      res_rad = z_abs;
    end else begin
      res_az  = p2_az;
      res_ph  = ph_full[DW-1] ? '1 : ph_full[DW-2:0];
      res_rad = (|r_full[RW-1:DW]) ? '1 : r_full[DW-1:0];
    end
  end

  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || (en && p2_v);
      skid_v_r <= 1'b0;
    end else if (en && p2_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_az_r  <= skid_az_r;
        out_ph_r  <= skid_ph_r;
        out_rad_r <= skid_rad_r;
      end else begin
        out_az_r  <= res_az;
        out_ph_r  <= res_ph;
        out_rad_r <= res_rad;
      end
    end else if (en) begin
      skid_az_r  <= res_az;
      skid_ph_r  <= res_ph;
      skid_rad_r <= res_rad;
    end
  end

  assign out_valid       = out_v_r;
  assign out_azimuth     = out_az_r;
  assign out_polar_angle = out_ph_r;
  assign out_radius      = out_rad_r;

  // skid entry only ever backs up a waiting output register
  `C2S_NEVER(a_skid_alone, skid_v_r && !out_v_r, "skid entry holds data with output empty")
  `C2S_ASSERT(a_skid_fill, $rose(skid_v_r) |-> $past(out_v_r && !out_ready),
              "skid entry filled while output was free")
  `C2S_ASSERT(a_result_lands, (out_free && !skid_v_r && p2_v) |=> out_v_r,
              "pipeline result lost on the way to the output")

endmodule

`default_nettype wire
